@@ src/tosd_pkg.sv @@
// shared types and constants for the tilt orientation and shake detector
`default_nettype none

package tosd_pkg;

	// default raw sample width of every sensor axis
	localparam int SAMPLE_WIDTH = 16;

	// gyro threshold register
	localparam int THRESH_W = 15;
	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd1143;

	// pitch zone, also the reported orientation code
	typedef enum logic [1:0] {
		ZONE_LEFT  = 2'd0,
		ZONE_RIGHT = 2'd1,
		ZONE_UP    = 2'd2,
		ZONE_NONE  = 2'd3
	} zone_t;

	typedef enum logic [1:0] {
		SHAKE_NONE  = 2'd0,
		SHAKE_START = 2'd1,
		SHAKE_STOP  = 2'd2
	} shake_ev_t;

	typedef enum logic [1:0] {
		ORIENT_NONE  = 2'd0,
		ORIENT_LEFT  = 2'd1,
		ORIENT_RIGHT = 2'd2,
		ORIENT_UP    = 2'd3
	} orient_ev_t;

endpackage

`default_nettype wire

@@ src/tilt_orientation_shake_detector.sv @@
// tilt orientation and shake detector: sample register, qualify logic, result register
`default_nettype none

// Takes one raw IMU sample word (three accel axes, three gyro axes, two's
// complement) per cycle and returns one result word per sample. A shake starts
// when any gyro axis magnitude is above gyro_threshold on two consecutive
// samples and stops on the first sample with all axes at or below it. The
// pitch zone is left when accel_x > 0 and accel_x^2 > 3*(accel_y^2+accel_z^2),
// right when accel_x < 0 with the same test, up otherwise; a zone is reported
// once it has been seen on two consecutive samples, with an event on each
// change. Throughput is one word per cycle; a word goes through the sample
// register, then the result register; the path between them is the three axis
// squarers followed by the add and compare of the zone test. The input side
// stalls only while a result word is held and the output side stalls. The
// threshold register is written through the cfg port and is meant to be
// changed only while no word is in flight; cfg_ready is always high.
module tilt_orientation_shake_detector #(
	parameter int SAMPLE_WIDTH = tosd_pkg::SAMPLE_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// sample channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      accel_z,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      gyro_x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      gyro_y,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      gyro_z,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [1:0]                               shake_event,
	output logic [1:0]                               orient_event,
	output logic                                     shaking,
	output logic [1:0]                               current_orientation,
	// threshold write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tosd_pkg::THRESH_W-1:0]       gyro_threshold
);

	localparam int W     = SAMPLE_WIDTH;
	// gyro magnitude vs threshold compare width
	localparam int CMP_W = (W > tosd_pkg::THRESH_W) ? W : tosd_pkg::THRESH_W;
	// squares need 2W bits, three times a sum of two squares needs 2W+1
	localparam int SQ_W  = 2 * W;
	localparam int RHS_W = 2 * W + 1;

	// threshold register
	logic [tosd_pkg::THRESH_W-1:0] thr_q;

	// sample register
	logic                valid_s1;
	logic signed [W-1:0] accel_x_s1, accel_y_s1, accel_z_s1;
	logic signed [W-1:0] gyro_x_s1, gyro_y_s1, gyro_z_s1;

	// detector state
	logic                shake_seen_q;
	logic                shake_active_q;
	tosd_pkg::zone_t     last_zone_q;
	tosd_pkg::zone_t     reported_q;

	// result register
	logic                  out_valid_q;
	tosd_pkg::shake_ev_t   shake_ev_q;
	tosd_pkg::orient_ev_t  orient_ev_q;

	// handshake
	logic out_free;
	logic advance;
	logic in_take;

	// next-state logic
	logic [W-1:0]        mag_ax, mag_ay, mag_az;
	logic [W-1:0]        mag_gx, mag_gy, mag_gz;
	logic [SQ_W-1:0]     sq_x, sq_y, sq_z;
	logic [RHS_W-1:0]    sum_yz, rhs, lhs;
	logic [CMP_W-1:0]    thr_ext;
	logic                moving;
	tosd_pkg::zone_t     zone;
	logic                shake_seen_d;
	logic                shake_active_d;
	tosd_pkg::shake_ev_t shake_ev_d;
	tosd_pkg::zone_t     reported_d;
	tosd_pkg::orient_ev_t orient_ev_d;

	// result register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tosd_pkg::THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= gyro_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// sample payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			accel_x_s1 <= accel_x;
			accel_y_s1 <= accel_y;
			accel_z_s1 <= accel_z;
			gyro_x_s1  <= gyro_x;
			gyro_y_s1  <= gyro_y;
			gyro_z_s1  <= gyro_z;
		end
	end

	// axis magnitudes; the most negative value maps to 2^(W-1), still in W bits
	always_comb begin
		mag_ax = accel_x_s1[W-1] ? (~accel_x_s1 + 1'b1) : accel_x_s1;
		mag_ay = accel_y_s1[W-1] ? (~accel_y_s1 + 1'b1) : accel_y_s1;
		mag_az = accel_z_s1[W-1] ? (~accel_z_s1 + 1'b1) : accel_z_s1;
		mag_gx = gyro_x_s1[W-1]  ? (~gyro_x_s1 + 1'b1)  : gyro_x_s1;
		mag_gy = gyro_y_s1[W-1]  ? (~gyro_y_s1 + 1'b1)  : gyro_y_s1;
		mag_gz = gyro_z_s1[W-1]  ? (~gyro_z_s1 + 1'b1)  : gyro_z_s1;
	end

	// strict threshold on any gyro axis
	always_comb begin
		thr_ext = CMP_W'(thr_q);
		moving  = (CMP_W'(mag_gx) > thr_ext) ||
		          (CMP_W'(mag_gy) > thr_ext) ||
		          (CMP_W'(mag_gz) > thr_ext);
	end

	// pitch zone: exact +-60 degree test on squared magnitudes
	always_comb begin
		sq_x   = SQ_W'(mag_ax) * SQ_W'(mag_ax);
		sq_y   = SQ_W'(mag_ay) * SQ_W'(mag_ay);
		sq_z   = SQ_W'(mag_az) * SQ_W'(mag_az);
		sum_yz = RHS_W'(sq_y) + RHS_W'(sq_z);
		rhs    = (sum_yz << 1) + sum_yz;
		lhs    = RHS_W'(sq_x);
		// lhs > rhs already implies accel_x is not zero; boundary equality is up
		if (lhs > rhs) begin
			zone = accel_x_s1[W-1] ? tosd_pkg::ZONE_RIGHT : tosd_pkg::ZONE_LEFT;
		end else begin
			zone = tosd_pkg::ZONE_UP;
		end
	end

	// shake qualification
	always_comb begin
		shake_seen_d   = shake_seen_q;
		shake_active_d = shake_active_q;
		shake_ev_d     = tosd_pkg::SHAKE_NONE;
		if (moving) begin
			if (shake_seen_q && !shake_active_q) begin
				shake_active_d = 1'b1;
				shake_ev_d     = tosd_pkg::SHAKE_START;
			end else begin
				shake_seen_d = 1'b1;
			end
		end else begin
			shake_seen_d = 1'b0;
			if (shake_active_q) begin
				shake_active_d = 1'b0;
				shake_ev_d     = tosd_pkg::SHAKE_STOP;
			end
		end
	end

	// orientation qualification: a zone must repeat before it is reported
	always_comb begin
		reported_d  = reported_q;
		orient_ev_d = tosd_pkg::ORIENT_NONE;
		if (last_zone_q == zone && reported_q != zone) begin
			reported_d = zone;
			unique case (zone)
				tosd_pkg::ZONE_LEFT:  orient_ev_d = tosd_pkg::ORIENT_LEFT;
				tosd_pkg::ZONE_RIGHT: orient_ev_d = tosd_pkg::ORIENT_RIGHT;
				tosd_pkg::ZONE_UP:    orient_ev_d = tosd_pkg::ORIENT_UP;
				default:              orient_ev_d = tosd_pkg::ORIENT_NONE;
			endcase
		end
	end

	// state moves only when a word enters the result register, so it
	// always matches the word on display there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shake_seen_q   <= 1'b0;
			shake_active_q <= 1'b0;
			last_zone_q    <= tosd_pkg::ZONE_NONE;
			reported_q     <= tosd_pkg::ZONE_NONE;
		end else if (advance) begin
			shake_seen_q   <= shake_seen_d;
			shake_active_q <= shake_active_d;
			// last zone always ends up equal to this sample's zone
			last_zone_q    <= zone;
			reported_q     <= reported_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// event payload, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			shake_ev_q  <= shake_ev_d;
			orient_ev_q <= orient_ev_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign shake_event         = shake_ev_q;
	assign orient_event        = orient_ev_q;
	assign shaking             = shake_active_q;
	assign current_orientation = reported_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking testbench for the tilt orientation and shake detector
`timescale 1ns / 100ps

module tb;

	localparam int SW = tosd_pkg::SAMPLE_WIDTH;
	localparam int THRESH_MAX = (1 << tosd_pkg::THRESH_W) - 1;

	typedef logic signed [SW-1:0] axis_t;

	// one raw sensor word as offered on the sample channel
	typedef struct {
		axis_t ax, ay, az;
		axis_t gx, gy, gz;
	} imu_word_t;

	// one result word, typed with the package codes
	typedef struct {
		tosd_pkg::shake_ev_t  shake_ev;
		tosd_pkg::orient_ev_t orient_ev;
		logic                 shaking;
		tosd_pkg::zone_t      orient;
	} report_t;

	// tracks shake and tilt state alongside the block and checks its result words
	class tilt_shake_tracker;
		logic [tosd_pkg::THRESH_W-1:0] threshold;
		logic                          shake_seen;
		logic                          shake_active;
		tosd_pkg::zone_t               last_zone;
		tosd_pkg::zone_t               reported;
		report_t                       expected_reports[$];
		int                            mismatches;

		function new();
			threshold    = tosd_pkg::THRESHOLD_RESET;
			shake_seen   = 1'b0;
			shake_active = 1'b0;
			last_zone    = tosd_pkg::ZONE_NONE;
			reported     = tosd_pkg::ZONE_NONE;
			mismatches   = 0;
		endfunction

		// two's complement magnitude; the most negative value comes out as 2^(SW-1)
		function logic [SW-1:0] magnitude(axis_t v);
			return v[SW-1] ? -v : v;
		endfunction

		// pitch zone from exact squared magnitudes, no trig
		function tosd_pkg::zone_t classify_tilt(axis_t ax, axis_t ay, axis_t az);
			logic [63:0] mx, my, mz;
			mx = 64'(magnitude(ax));
			my = 64'(magnitude(ay));
			mz = 64'(magnitude(az));
			if (mx != 0 && mx * mx > 3 * (my * my + mz * mz))
				return ax[SW-1] ? tosd_pkg::ZONE_RIGHT : tosd_pkg::ZONE_LEFT;
			return tosd_pkg::ZONE_UP;
		endfunction

		function report_t predict_report(imu_word_t w);
			report_t         r;
			logic            moving;
			tosd_pkg::zone_t zone;
			r.shake_ev  = tosd_pkg::SHAKE_NONE;
			r.orient_ev = tosd_pkg::ORIENT_NONE;
			moving = magnitude(w.gx) > threshold || magnitude(w.gy) > threshold ||
				magnitude(w.gz) > threshold;
			zone = classify_tilt(w.ax, w.ay, w.az);

			// shake needs two moving samples in a row, one quiet sample ends it
			if (moving) begin
				if (shake_seen && !shake_active) begin
					shake_active = 1'b1;
					r.shake_ev   = tosd_pkg::SHAKE_START;
				end else
					shake_seen = 1'b1;
			end else begin
				shake_seen = 1'b0;
				if (shake_active) begin
					shake_active = 1'b0;
					r.shake_ev   = tosd_pkg::SHAKE_STOP;
				end
			end

			// zone must repeat before it is reported
			if (last_zone == zone && reported != zone) begin
				reported = zone;
				case (zone)
					tosd_pkg::ZONE_LEFT:  r.orient_ev = tosd_pkg::ORIENT_LEFT;
					tosd_pkg::ZONE_RIGHT: r.orient_ev = tosd_pkg::ORIENT_RIGHT;
					default:              r.orient_ev = tosd_pkg::ORIENT_UP;
				endcase
			end else
				last_zone = zone;

			r.shaking = shake_active;
			r.orient  = reported;
			return r;
		endfunction

		function void note_sample(imu_word_t w);
			expected_reports.push_back(predict_report(w));
		endfunction

		function void check_report(logic [1:0] se, logic [1:0] oe, logic sh, logic [1:0] co);
			report_t e;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with no sample pending: %0d %0d %0d %0d",
						$time, se, oe, sh, co);
				return;
			end
			e = expected_reports.pop_front();
			if (se !== e.shake_ev || oe !== e.orient_ev || sh !== e.shaking ||
					co !== e.orient) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch shake_event exp %0d got %0d, ", $time,
						e.shake_ev, se, "orient_event exp %0d got %0d, ", e.orient_ev, oe,
						"shaking exp %0d got %0d, ", e.shaking, sh,
						"orientation exp %0d got %0d", e.orient, co);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	axis_t                         accel_x = '0, accel_y = '0, accel_z = '0;
	axis_t                         gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    shake_event, orient_event, current_orientation;
	logic                          shaking;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tosd_pkg::THRESH_W-1:0] gyro_threshold = '0;

	tilt_shake_tracker tracker;

	// idling knobs, changed per phase by the stimulus process
	bit tx_gappy = 1'b0;
	bit rx_gappy = 1'b0;
	// set by the stimulus to ask the receiver for one long hold-off
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	tilt_orientation_shake_detector #(
		.SAMPLE_WIDTH(SW)
	) u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.accel_x            (accel_x),
		.accel_y            (accel_y),
		.accel_z            (accel_z),
		.gyro_x             (gyro_x),
		.gyro_y             (gyro_y),
		.gyro_z             (gyro_z),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.shake_event        (shake_event),
		.orient_event       (orient_event),
		.shaking            (shaking),
		.current_orientation(current_orientation),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.gyro_threshold     (gyro_threshold)
	);

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
	endfunction

	function automatic imu_word_t make_word(int ax, int ay, int az, int gx, int gy, int gz);
		imu_word_t w;
		w.ax = axis_t'(ax);
		w.ay = axis_t'(ay);
		w.az = axis_t'(az);
		w.gx = axis_t'(gx);
		w.gy = axis_t'(gy);
		w.gz = axis_t'(gz);
		return w;
	endfunction

	// one gyro axis either above the threshold or at/below it, random sign
	function automatic axis_t gyro_axis(bit over, logic [tosd_pkg::THRESH_W-1:0] thr);
		int m;
		if (over)
			m = $urandom_range(32768, int'(thr) + 1);
		else
			m = $urandom_range(int'(thr), 0);
		if (m == 32768)
			return axis_t'(-32768);
		return $urandom_range(1) ? axis_t'(-m) : axis_t'(m);
	endfunction

	// word aimed at a zone and a motion state; ZONE_NONE gives unshaped noise
	function automatic imu_word_t shaped_word(tosd_pkg::zone_t zone, bit moving,
			logic [tosd_pkg::THRESH_W-1:0] thr);
		imu_word_t w;
		int        big, lim;
		big = $urandom_range(32767, 4096);
		lim = big / 4;
		w.ax = axis_t'(int'($urandom_range(2 * lim)) - lim);
		w.ay = axis_t'(int'($urandom_range(2 * lim)) - lim);
		w.az = axis_t'(int'($urandom_range(2 * lim)) - lim);
		case (zone)
			tosd_pkg::ZONE_LEFT:  w.ax = axis_t'(big);
			tosd_pkg::ZONE_RIGHT: w.ax = axis_t'(-big - int'($urandom_range(1)));
			tosd_pkg::ZONE_UP: begin
				if ($urandom_range(1))
					w.az = $urandom_range(1) ? axis_t'(big) : axis_t'(-big);
				else
					w.ay = $urandom_range(1) ? axis_t'(big) : axis_t'(-big);
			end
			default: begin
				w.ax = axis_t'($urandom);
				w.ay = axis_t'($urandom);
				w.az = axis_t'($urandom);
			end
		endcase
		w.gx = gyro_axis(1'b0, thr);
		w.gy = gyro_axis(1'b0, thr);
		w.gz = gyro_axis(1'b0, thr);
		if (moving) begin
			case ($urandom_range(2))
				0:       w.gx = gyro_axis(1'b1, thr);
				1:       w.gy = gyro_axis(1'b1, thr);
				default: w.gz = gyro_axis(1'b1, thr);
			endcase
		end
		if (zone == tosd_pkg::ZONE_NONE) begin
			w.gx = axis_t'($urandom);
			w.gy = axis_t'($urandom);
			w.gz = axis_t'($urandom);
		end
		return w;
	endfunction

	// offer one word, hold it until taken, then maybe idle a while
	task automatic send_word(imu_word_t w);
		in_valid <= 1'b1;
		accel_x  <= w.ax;
		accel_y  <= w.ay;
		accel_z  <= w.az;
		gyro_x   <= w.gx;
		gyro_y   <= w.gy;
		gyro_z   <= w.gz;
		do @(posedge clk); while (in_stall);
		tracker.note_sample(w);
		if (tx_gappy && $urandom_range(2) == 0) begin
			in_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	// threshold changes only once the pipeline has emptied
	task automatic write_threshold(logic [tosd_pkg::THRESH_W-1:0] value);
		in_valid <= 1'b0;
		while (tracker.expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid      <= 1'b1;
		gyro_threshold <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.threshold = value;
		cfg_valid <= 1'b0;
	endtask

	// edge cases at the reset threshold of 1143
	task automatic run_directed();
		// all accel zero counts as up, then up qualifies, then repeats quietly
		send_word(make_word(0, 0, 0, 0, 0, 0));
		send_word(make_word(0, 0, 0, 0, 0, 0));
		send_word(make_word(0, 0, 0, 0, 0, 0));
		// full-scale left with gyro over on each axis in turn: shake starts, left reported
		send_word(make_word(32767, 0, 0, 32767, 0, 0));
		send_word(make_word(32767, 0, 0, 0, 32767, 0));
		send_word(make_word(32767, -5, 3, 0, 0, 32767));
		// most negative samples: magnitude beats any threshold, tilt goes right
		send_word(make_word(-32768, 0, 0, -32768, 0, 0));
		send_word(make_word(-32768, 100, -100, 0, 0, -32768));
		// gyro exactly at threshold is quiet; accel just inside the left boundary
		send_word(make_word(1000, 577, 0, 1143, -1143, 1143));
		send_word(make_word(1000, 577, 0, 0, 0, 0));
		// just outside the boundary is up
		send_word(make_word(1000, 578, 0, 0, 0, 0));
		send_word(make_word(1000, 0, 578, 0, 0, 0));
		// one moving sample alone does not start a shake
		send_word(make_word(-1000, -577, 0, -1144, 0, 0));
		send_word(make_word(-1000, 0, -577, 0, 0, 0));
		// every accel axis at its minimum still counts as up
		send_word(make_word(-32768, -32768, -32768, 0, -1144, 0));
		// tiny values right around the boundary
		send_word(make_word(7, 4, 0, 0, 1144, 0));
		send_word(make_word(7, 4, 1, 0, 0, -1144));
		send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767));
		send_word(make_word(0, 0, 0, 0, 0, 0));
	endtask

	// runs of same zone and motion so shake and tilt qualification get exercised;
	// single-word runs break sequences, ZONE_NONE runs are plain noise
	task automatic run_random(int count);
		tosd_pkg::zone_t zone;
		bit              moving;
		int              run;
		while (count > 0) begin
			zone   = tosd_pkg::zone_t'($urandom_range(3));
			moving = ($urandom_range(1) != 0);
			run    = $urandom_range(5, 1);
			repeat (run) begin
				send_word(shaped_word(zone, moving, tracker.threshold));
				count--;
			end
		end
	endtask

	// result side: check every word taken, then pick the stall for the next cycle
	int stall_left = 0;
	int hold_left  = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_report(shake_event, orient_event, shaking, current_orientation);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				// long hold-off so the block backs up and stalls its input
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_gappy && $urandom_range(3) == 0) begin
				out_stall  <= 1'b1;
				stall_left = idle_len() - 1;
			end else
				out_stall <= 1'b0;
		end
	end

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases back to back, then again with gaps on both sides
		run_directed();
		tx_gappy = 1'b1;
		rx_gappy = 1'b1;
		run_directed();

		// zero threshold: any nonzero gyro axis counts as motion
		write_threshold('0);
		run_random(150);

		// full-scale threshold: only the most negative gyro value moves
		tx_gappy = 1'b0;
		write_threshold(tosd_pkg::THRESH_W'(THRESH_MAX));
		run_random(150);

		write_threshold(tosd_pkg::THRESH_W'($urandom_range(THRESH_MAX)));
		tx_gappy = 1'b1;
		rx_gappy = 1'b0;
		run_random(150);

		// back at reset value, receiver holds off while the sender keeps pushing
		write_threshold(tosd_pkg::THRESHOLD_RESET);
		tx_gappy = 1'b0;
		rx_gappy = 1'b1;
		hold_req = 1'b1;
		run_random(150);

		write_threshold(tosd_pkg::THRESH_W'($urandom_range(300)));
		tx_gappy = 1'b1;
		run_random(150);

		// drain whatever is still in flight
		in_valid <= 1'b0;
		while (tracker.expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ tilt_orientation_shake_detector.f @@
src/tosd_pkg.sv
src/tilt_orientation_shake_detector.sv
bench/tb.sv
